FILE: src/voice_activity_trigger_assert.svh
// ----------------------------------------------------------------------------
// voice activity trigger assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef VOICE_ACTIVITY_TRIGGER_ASSERT_SVH
`define VOICE_ACTIVITY_TRIGGER_ASSERT_SVH

// same-cycle implication
`define VAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("voice_activity_trigger check failed");

// next-cycle implication
`define VAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("voice_activity_trigger check failed");

`endif

FILE: src/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg
// shared constants for the voice activity trigger
// ----------------------------------------------------------------------------
`default_nettype none

package vat_pkg;

    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int EVENT_W  = 2;
    localparam int FLUSH_W  = 6;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;
    typedef logic [EVENT_W-1:0]   event_t;

    localparam cfg_idx_t REG_WINDOW_FRAMES   = 2'd0;
    localparam cfg_idx_t REG_START_THRESHOLD = 2'd1;
    localparam cfg_idx_t REG_STOP_THRESHOLD  = 2'd2;

    localparam cfg_val_t WINDOW_FRAMES_RST   = 6'd10;
    localparam cfg_val_t START_THRESHOLD_RST = 6'd7;
    localparam cfg_val_t STOP_THRESHOLD_RST  = 6'd7;

    localparam event_t EV_NONE   = 2'd0;
    localparam event_t EV_SPEECH = 2'd1;
    localparam event_t EV_END    = 2'd2;

endpackage

`default_nettype wire

FILE: src/voice_activity_trigger.sv
// Voice activity trigger: takes one voiced/unvoiced frame flag per item and returns one
// result per item. An item can be accepted every cycle, and its result is in the output
// register on the next cycle. A result that waits there holds off the input unless it is
// taken in the same cycle.
// The padding window is a shift register with a running fill and voiced count, so each
// item is a single update. After window_frames is written smaller than the number of
// frames currently held, the input stalls while the oldest flags are dropped one at a
// time until the fill fits the window.
// ----------------------------------------------------------------------------
// voice_activity_trigger
// padding-window speech start and end detection on per-frame voice flags
// ----------------------------------------------------------------------------
`default_nettype none

module voice_activity_trigger #(
    parameter int MAX_WINDOW = 32
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire                      s_frame_voiced,
    output logic                     m_valid,
    input  wire                      m_ready,
    output vat_pkg::event_t          m_event_res,
    output logic [vat_pkg::FLUSH_W-1:0] m_flush_count,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire vat_pkg::cfg_idx_t   cfg_index,
    input  wire vat_pkg::cfg_val_t   cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = CNT_W + vat_pkg::CFG_W + vat_pkg::FLUSH_W;

    vat_pkg::cfg_val_t win_cfg_reg, start_thr_reg, stop_thr_reg;

    logic [MAX_WINDOW-1:0] flags_reg, flags_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]      voiced_reg, voiced_next;
    logic                  speech_reg, speech_next;

    logic                  out_valid_reg;
    vat_pkg::event_t       event_reg, event_next;
    logic [vat_pkg::FLUSH_W-1:0] flush_reg, flush_next;

    logic [CW-1:0]    win_ext;
    logic [CNT_W-1:0] eff_win;
    logic             trim;
    logic             accept;
    logic [IDX_W-1:0] oldest_idx;
    logic             oldest_bit;
    logic [CNT_W-1:0] fill_push, voiced_push;
    logic [CNT_W-1:0] unvoiced_push;

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb begin
        win_ext = CW'(win_cfg_reg);
        if (win_ext == '0) begin
            win_ext = CW'(1);
        end else if (win_ext > CW'(MAX_WINDOW)) begin
            win_ext = CW'(MAX_WINDOW);
        end
        eff_win = win_ext[CNT_W-1:0];
    end

    assign trim       = (fill_reg > eff_win);
    assign accept     = s_valid && s_ready;
    assign s_ready    = !trim && (!out_valid_reg || m_ready);
    assign cfg_ready  = 1'b1;
    assign oldest_idx = IDX_W'(fill_reg - CNT_W'(1));
    assign oldest_bit = flags_reg[oldest_idx];

    // window after the push of the new flag
    always_comb begin
        if (fill_reg == eff_win) begin
            fill_push   = fill_reg;
            voiced_push = voiced_reg - CNT_W'(oldest_bit) + CNT_W'(s_frame_voiced);
        end else begin
            fill_push   = fill_reg + CNT_W'(1);
            voiced_push = voiced_reg + CNT_W'(s_frame_voiced);
        end
        unvoiced_push = fill_push - voiced_push;
    end

    always_comb begin
        flags_next  = flags_reg;
        fill_next   = fill_reg;
        voiced_next = voiced_reg;
        speech_next = speech_reg;
        event_next  = event_reg;
        flush_next  = flush_reg;
        if (trim) begin
            fill_next   = fill_reg - CNT_W'(1);
            voiced_next = voiced_reg - CNT_W'(oldest_bit);
        end else if (accept) begin
            for (int i = MAX_WINDOW - 1; i > 0; i--) begin
                flags_next[i] = flags_reg[i-1];
            end
            flags_next[0] = s_frame_voiced;
            fill_next     = fill_push;
            voiced_next   = voiced_push;
            event_next    = vat_pkg::EV_NONE;
            flush_next    = '0;
            if (!speech_reg) begin
                if (CW'(voiced_push) > CW'(start_thr_reg)) begin
                    speech_next = 1'b1;
                    event_next  = vat_pkg::EV_SPEECH;
                    flush_next  = vat_pkg::FLUSH_W'(fill_push);
                    fill_next   = '0;
                    voiced_next = '0;
                end
            end else begin
                event_next = vat_pkg::EV_SPEECH;
                flush_next = vat_pkg::FLUSH_W'(1);
                if (CW'(unvoiced_push) > CW'(stop_thr_reg)) begin
                    speech_next = 1'b0;
                    event_next  = vat_pkg::EV_END;
                    fill_next   = '0;
                    voiced_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg   <= vat_pkg::WINDOW_FRAMES_RST;
            start_thr_reg <= vat_pkg::START_THRESHOLD_RST;
            stop_thr_reg  <= vat_pkg::STOP_THRESHOLD_RST;
            fill_reg      <= '0;
            voiced_reg    <= '0;
            speech_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vat_pkg::REG_WINDOW_FRAMES:   win_cfg_reg   <= cfg_data;
                    vat_pkg::REG_START_THRESHOLD: start_thr_reg <= cfg_data;
                    vat_pkg::REG_STOP_THRESHOLD:  stop_thr_reg  <= cfg_data;
                    default: ;
                endcase
            end
            fill_reg   <= fill_next;
            voiced_reg <= voiced_next;
            speech_reg <= speech_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        flags_reg <= flags_next;
        event_reg <= event_next;
        flush_reg <= flush_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_event_res   = event_reg;
    assign m_flush_count = flush_reg;

endmodule

`default_nettype wire

FILE: src/vat_checker.sv
// ----------------------------------------------------------------------------
// vat_checker
// port-level checks for the voice activity trigger, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "voice_activity_trigger_assert.svh"

module vat_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire vat_pkg::event_t         m_event_res,
    input wire [vat_pkg::FLUSH_W-1:0]   m_flush_count
);

    `VAT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_event_res) && $stable(m_flush_count))

    `VAT_ASSERT_NEXT(a_item_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)

    `VAT_ASSERT_NOW(a_idle_no_flush, aclk, aresetn,
        m_valid && (m_event_res == vat_pkg::EV_NONE), m_flush_count == '0)

    `VAT_ASSERT_NOW(a_end_one_frame, aclk, aresetn,
        m_valid && (m_event_res == vat_pkg::EV_END), m_flush_count == vat_pkg::FLUSH_W'(1))

endmodule

bind voice_activity_trigger vat_checker u_vat_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_res   (m_event_res),
    .m_flush_count (m_flush_count)
);

`default_nettype wire
